>>> rtl/core/mlc_pkg.sv
package mlc_pkg;

    localparam int TOF_BITS    = 10;
    localparam int ENERGY_BITS = 8;

    // log unit sizing: channel, Q11.8 argument with sign, top-bit index
    localparam int LOG_CH_W = (TOF_BITS > ENERGY_BITS) ? TOF_BITS : ENERGY_BITS;
    localparam int XW       = LOG_CH_W + 10;
    localparam int PW       = $clog2(XW);
    localparam int LW       = PW + 16;
    localparam int UW       = 26;
    localparam int SQ_STEPS = 16;

    // x, top bit, normalize, squaring steps, ln scale, shift add
    localparam int LOG_LAT = 3 + SQ_STEPS + 2;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [2*TOF_BITS-1:0]    TOF_LIM_RST = {{TOF_BITS{1'b1}}, {TOF_BITS{1'b0}}};
    localparam logic [2*ENERGY_BITS-1:0] EN_LIM_RST  =
        {{ENERGY_BITS{1'b1}}, {ENERGY_BITS{1'b0}}};
    localparam logic [63:0] RES_LIM_RST = 64'h7FFF_FFFF_8000_0000;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOF_UNDER  = 3'd1,
        ST_TOF_OVER   = 3'd2,
        ST_EN_UNDER   = 3'd3,
        ST_EN_OVER    = 3'd4,
        ST_MASS_UNDER = 3'd5,
        ST_MASS_OVER  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CFG_TOF_LIMITS  = 3'd0,
        CFG_EN_LIMITS   = 3'd1,
        CFG_TOF_OS      = 3'd2,
        CFG_EN_OS       = 3'd3,
        CFG_COEF_A      = 3'd4,
        CFG_COEF_B      = 3'd5,
        CFG_COEF_C      = 3'd6,
        CFG_RES_LIMITS  = 3'd7
    } cfg_idx_t;

endpackage

>>> rtl/core/mlc_in_if.sv
interface mlc_in_if;
    logic                         valid;
    logic                         ready;
    logic [mlc_pkg::TOF_BITS-1:0]    tof_channel;
    logic [mlc_pkg::ENERGY_BITS-1:0] energy_channel;

    modport source (output valid, output tof_channel, output energy_channel, input ready);
    modport sink   (input valid, input tof_channel, input energy_channel, output ready);
endinterface

>>> rtl/core/mlc_out_if.sv
interface mlc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mass_value;
    logic [2:0]         status;

    modport source (output valid, output mass_value, output status, input ready);
    modport sink   (input valid, input mass_value, input status, output ready);
endinterface

>>> rtl/core/mlc_log.sv
// Pipelined natural log of (channel + offset) plus shift, signed Q9.16 out.
module mlc_log (
    input  logic                               clk,
    input  logic                               adv,
    input  logic [mlc_pkg::LOG_CH_W-1:0]       chan,
    input  logic [31:0]                        os,
    output logic signed [mlc_pkg::UW-1:0]      u
);
    localparam int XW = mlc_pkg::XW;
    localparam int PW = mlc_pkg::PW;
    localparam int LW = mlc_pkg::LW;
    localparam int UW = mlc_pkg::UW;
    localparam int NS = mlc_pkg::SQ_STEPS;

    logic signed [XW-1:0] x_next, x_reg, x2_reg;
    logic                 neg_reg [0:NS+3];
    logic [PW-1:0]        p_next, p_reg;
    logic [30:0]          m_reg [0:NS];
    logic [30:0]          m_next [0:NS];
    logic [15:0]          frac_reg [0:NS];
    logic [15:0]          frac_next [0:NS];
    logic [PW-1:0]        e_reg [0:NS];
    logic [LW+31:0]       prod;
    logic [LW-1:0]        ln_reg;
    logic [LW-1:0]        l_full;
    logic signed [UW-1:0] u_next, u_reg;
    logic [4:0]           lsh;
    logic [61:0]          sq [0:NS-1];

    always_comb
    begin
        x_next = $signed({1'b0, chan, 8'b0}) + XW'($signed(os[15:0]));
        p_next = '0;
        for (int i = 0; i < XW - 1; i++)
        begin
            if (x_reg[i])
                p_next = PW'(i);
        end
        lsh       = 5'(30 - int'(p_reg));
        m_next[0] = 31'(x2_reg[XW-2:0]) << lsh;
        frac_next[0] = '0;
        for (int k = 0; k < NS; k++)
        begin
            sq[k] = 62'(m_reg[k]) * 62'(m_reg[k]);
            if (sq[k][61])
            begin
                m_next[k+1]    = sq[k][61:31];
                frac_next[k+1] = {frac_reg[k][14:0], 1'b1};
            end
            else
            begin
                m_next[k+1]    = sq[k][60:30];
                frac_next[k+1] = {frac_reg[k][14:0], 1'b0};
            end
        end
        l_full = {e_reg[NS], frac_reg[NS]};
        prod   = (LW+32)'(l_full) * (LW+32)'(mlc_pkg::LN2_Q32) + (LW+32)'(64'h8000_0000);
        if (neg_reg[NS+3])
            u_next = -UW'(65536);
        else
            u_next = $signed(UW'(ln_reg)) + UW'($signed({os[31:16], 8'b0}));
    end

    // stage layout: x, top bit, normalize, squarings, ln scale, shift add
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg      <= x_next;
            neg_reg[0] <= (x_next < XW'(256));
            x2_reg     <= x_reg;
            neg_reg[1] <= neg_reg[0];
            p_reg      <= p_next;
            neg_reg[2] <= neg_reg[1];
            m_reg[0]    <= m_next[0];
            frac_reg[0] <= frac_next[0];
            e_reg[0]    <= p_reg - PW'(8);
            for (int k = 0; k < NS; k++)
            begin
                m_reg[k+1]    <= m_next[k+1];
                frac_reg[k+1] <= frac_next[k+1];
                e_reg[k+1]    <= e_reg[k];
            end
            for (int k = 3; k < NS + 4; k++)
                neg_reg[k] <= neg_reg[k-1];
            ln_reg <= prod[LW+31:32];
            u_reg  <= u_next;
        end
    end

    assign u = u_reg;
endmodule

>>> rtl/core/log_mass_classifier.sv
// Channel        | Dir | Payload                                   | Handshake
// ev_in          | in  | tof_channel, energy_channel               | valid/ready
// res_out        | out | mass_value (Q16.16), status               | valid/ready
// cfg            | in  | cfg_we, cfg_index, cfg_data (64b)         | write only
//
// One event enters per cycle unless a stall on res_out holds the pipe.
// The depth is set by the log unit: sixteen squaring steps, one per stage.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A stall on res_out freezes every stage at once; ev_in.ready drops only
// while the output register holds a transaction that is not taken.
module log_mass_classifier (
    input  logic            clk,
    input  logic            rst_n,
    mlc_in_if.sink          ev_in,
    mlc_out_if.source       res_out,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    localparam int TB = mlc_pkg::TOF_BITS;
    localparam int EB = mlc_pkg::ENERGY_BITS;
    localparam int UW = mlc_pkg::UW;
    localparam int LL = mlc_pkg::LOG_LAT;
    localparam int D  = LL + 7;

    // configuration registers
    logic [2*TB-1:0] tof_lim_reg;
    logic [2*EB-1:0] en_lim_reg;
    logic [31:0]     tof_os_reg, en_os_reg;
    logic [63:0]     coef_a_reg, coef_b_reg, coef_c_reg, res_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tof_lim_reg <= mlc_pkg::TOF_LIM_RST;
            en_lim_reg  <= mlc_pkg::EN_LIM_RST;
            tof_os_reg  <= '0;
            en_os_reg   <= '0;
            coef_a_reg  <= '0;
            coef_b_reg  <= '0;
            coef_c_reg  <= '0;
            res_lim_reg <= mlc_pkg::RES_LIM_RST;
        end
        else if (cfg_we)
        begin
            case (mlc_pkg::cfg_idx_t'(cfg_index))
                mlc_pkg::CFG_TOF_LIMITS: tof_lim_reg <= cfg_data[2*TB-1:0];
                mlc_pkg::CFG_EN_LIMITS:  en_lim_reg  <= cfg_data[2*EB-1:0];
                mlc_pkg::CFG_TOF_OS:     tof_os_reg  <= cfg_data[31:0];
                mlc_pkg::CFG_EN_OS:      en_os_reg   <= cfg_data[31:0];
                mlc_pkg::CFG_COEF_A:     coef_a_reg  <= cfg_data;
                mlc_pkg::CFG_COEF_B:     coef_b_reg  <= cfg_data;
                mlc_pkg::CFG_COEF_C:     coef_c_reg  <= cfg_data;
                mlc_pkg::CFG_RES_LIMITS: res_lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance the whole pipe unless the output holds an untaken transaction
    logic           adv;
    logic [D-1:0]   vld_reg;
    mlc_pkg::status_t stat_reg [0:D-1];
    mlc_pkg::status_t win_stat;

    assign adv         = !vld_reg[D-1] || res_out.ready;
    assign ev_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[D-2:0], ev_in.valid};
    end

    // window checks, time-of-flight first, under before over
    always_comb
    begin
        if (ev_in.tof_channel < tof_lim_reg[TB-1:0])
            win_stat = mlc_pkg::ST_TOF_UNDER;
        else if (ev_in.tof_channel > tof_lim_reg[2*TB-1:TB])
            win_stat = mlc_pkg::ST_TOF_OVER;
        else if (ev_in.energy_channel < en_lim_reg[EB-1:0])
            win_stat = mlc_pkg::ST_EN_UNDER;
        else if (ev_in.energy_channel > en_lim_reg[2*EB-1:EB])
            win_stat = mlc_pkg::ST_EN_OVER;
        else
            win_stat = mlc_pkg::ST_OK;
    end

    // log terms
    logic signed [UW-1:0] u, v;

    mlc_log u_tof_log (
        .clk  (clk),
        .adv  (adv),
        .chan (mlc_pkg::LOG_CH_W'(ev_in.tof_channel)),
        .os   (tof_os_reg),
        .u    (u)
    );

    mlc_log u_en_log (
        .clk  (clk),
        .adv  (adv),
        .chan (mlc_pkg::LOG_CH_W'(ev_in.energy_channel)),
        .os   (en_os_reg),
        .u    (v)
    );

    // coefficients
    logic signed [31:0] c0, c1, c2, c3, c4, c5;
    logic signed [31:0] mmin, mmax;
    assign c0   = $signed(coef_a_reg[31:0]);
    assign c1   = $signed(coef_a_reg[63:32]);
    assign c2   = $signed(coef_b_reg[31:0]);
    assign c3   = $signed(coef_b_reg[63:32]);
    assign c4   = $signed(coef_c_reg[31:0]);
    assign c5   = $signed(coef_c_reg[63:32]);
    assign mmin = $signed(res_lim_reg[31:0]);
    assign mmax = $signed(res_lim_reg[63:32]);

    // polynomial stages; every product is floored back by an arithmetic shift
    logic signed [UW-1:0] u1_reg, v1_reg, u2_reg, v2_reg, u3_reg;
    logic signed [33:0]   c5u_reg, c3u_reg, c4v_reg;
    logic signed [43:0]   c5uu_reg;
    logic signed [35:0]   esum_reg;
    logic signed [44:0]   ts_reg;
    logic signed [45:0]   et3_reg, et4_reg, et5_reg;
    logic signed [48:0]   tlo_reg, thi_reg;
    logic signed [54:0]   tt_reg;
    logic signed [31:0]   m_reg, mass_reg;

    logic signed [57:0]   p_c5u, p_c3u, p_c4v;
    logic signed [59:0]   p_c5uu;
    logic signed [61:0]   p_et;
    logic signed [70:0]   p_tt;
    logic signed [56:0]   m_sum;
    logic signed [31:0]   m_sat;
    mlc_pkg::status_t     fin_stat;

    always_comb
    begin
        p_c5u  = 58'(c5) * 58'(u);
        p_c3u  = 58'(c3) * 58'(u);
        p_c4v  = 58'(c4) * 58'(v);
        p_c5uu = 60'(c5u_reg) * 60'(u1_reg);
        p_et   = 62'(v2_reg) * 62'(esum_reg);
        p_tt   = (71'(thi_reg) <<< 22) + 71'(tlo_reg);
        m_sum  = 57'(c0 >>> 8) + 57'(et5_reg) + 57'(tt_reg);
        if (m_sum > 57'sh7FFF_FFFF)
            m_sat = 32'sh7FFF_FFFF;
        else if (m_sum < -57'sh8000_0000)
            m_sat = -32'sh8000_0000;
        else
            m_sat = m_sum[31:0];
        if (stat_reg[D-2] != mlc_pkg::ST_OK)
            fin_stat = stat_reg[D-2];
        else if (m_reg < mmin)
            fin_stat = mlc_pkg::ST_MASS_UNDER;
        else if (m_reg > mmax)
            fin_stat = mlc_pkg::ST_MASS_OVER;
        else
            fin_stat = mlc_pkg::ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stat_reg[0] <= win_stat;
            for (int k = 1; k < D - 1; k++)
                stat_reg[k] <= stat_reg[k-1];
            stat_reg[D-1] <= fin_stat;

            u1_reg  <= u;
            v1_reg  <= v;
            c5u_reg <= p_c5u[57:24];
            c3u_reg <= p_c3u[57:24];
            c4v_reg <= p_c4v[57:24];

            u2_reg   <= u1_reg;
            v2_reg   <= v1_reg;
            c5uu_reg <= p_c5uu[59:16];
            esum_reg <= 36'(c1 >>> 8) + 36'(c3u_reg) + 36'(c4v_reg);

            u3_reg  <= u2_reg;
            ts_reg  <= 45'(c2 >>> 8) + 45'(c5uu_reg);
            et3_reg <= p_et[61:16];

            // split the wide product into two partials
            tlo_reg <= 49'(u3_reg) * 49'($signed({1'b0, ts_reg[21:0]}));
            thi_reg <= 49'(u3_reg) * 49'($signed(ts_reg[44:22]));
            et4_reg <= et3_reg;

            tt_reg  <= p_tt[70:16];
            et5_reg <= et4_reg;

            m_reg <= m_sat;

            mass_reg <= (fin_stat == mlc_pkg::ST_OK) ? m_reg : 32'sd0;
        end
    end

    assign res_out.valid      = vld_reg[D-1];
    assign res_out.mass_value = mass_reg;
    assign res_out.status     = stat_reg[D-1];
endmodule

>>> rtl/core/mlc_checker.sv
module mlc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] mass_value,
    input logic [2:0]  status
);
    // hold a result that is not taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // never stall the input with an empty output register
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mlc_pkg::ST_OK |-> mass_value == 32'd0)
        else $error("nonzero mass on failed status");

    a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 3'd7)
        else $error("status code out of range");
endmodule

bind log_mass_classifier mlc_checker u_mlc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (ev_in.valid),
    .in_ready   (ev_in.ready),
    .out_valid  (res_out.valid),
    .out_ready  (res_out.ready),
    .mass_value (res_out.mass_value),
    .status     (res_out.status)
);
